>>> design/mmof_pkg.sv
// Shared constants, types and helpers of the multimode one-pole filter.
`default_nettype none
package mmof_pkg;

  localparam int ORDER_MAX   = 16;
  localparam int SAMPLE_BITS = 24;
  localparam int IDX_W       = (ORDER_MAX > 1) ? $clog2(ORDER_MAX) : 1;
  localparam int ST_W        = 32;   // stage state width
  localparam int OPND_W      = 36;   // multiplier data operand
  localparam int COEF_W      = 20;   // multiplier coefficient operand
  localparam int MUL_W       = 41;   // rounded product
  localparam int WIDE_W      = MUL_W + 1;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_IDX_W   = 3;

  localparam logic [2:0] MODE_BYPASS = 3'd0;
  localparam logic [2:0] MODE_LOW1   = 3'd1;
  localparam logic [2:0] MODE_HIGH1  = 3'd2;
  localparam logic [2:0] MODE_BAND1  = 3'd3;
  localparam logic [2:0] MODE_LOWN   = 3'd4;
  localparam logic [2:0] MODE_HIGHN  = 3'd5;
  localparam logic [2:0] MODE_BANDN  = 3'd6;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAGES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SGAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OGAIN  = 3'd5;

  localparam logic [16:0] FREQ_ONE = 17'd65536;

  typedef struct packed {
    logic [2:0]  filter_mode;
    logic [4:0]  stage_count;
    logic [16:0] freq_coef;
    logic [15:0] reso_coef;
    logic [19:0] stage_gain;
    logic [19:0] out_gain;
  } cfg_t;

  // Saturate a wide signed value to the int32 range.
  function automatic logic signed [ST_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-ST_W:0] top;
    top = v[WIDE_W-1:ST_W-1];
    if (top == '0 || top == '1) begin
      return v[ST_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ST_W-1){1'b1}}};
    end
  endfunction

  // Saturating difference of two state values.
  function automatic logic signed [ST_W-1:0] sat_sub(input logic signed [ST_W-1:0] a,
                                                     input logic signed [ST_W-1:0] b);
    return sat32(WIDE_W'(a) - WIDE_W'(b));
  endfunction

endpackage
`default_nettype wire

>>> design/mmof_cfg.sv
// Configuration register file of the multimode one-pole filter.
`default_nettype none
module mmof_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  input  wire logic [mmof_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mmof_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                     cfg_ready,
  output mmof_pkg::cfg_t                           cfg
);

  mmof_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        mmof_pkg::REG_MODE:   cfg_nxt.filter_mode = cfg_data[2:0];
        mmof_pkg::REG_STAGES: cfg_nxt.stage_count = cfg_data[4:0];
        mmof_pkg::REG_FREQ:   cfg_nxt.freq_coef   = cfg_data[16:0];
        mmof_pkg::REG_RESO:   cfg_nxt.reso_coef   = cfg_data[15:0];
        mmof_pkg::REG_SGAIN:  cfg_nxt.stage_gain  = cfg_data[19:0];
        mmof_pkg::REG_OGAIN:  cfg_nxt.out_gain    = cfg_data[19:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_mode <= mmof_pkg::MODE_LOW1;
      cfg_r.stage_count <= 5'd1;
      cfg_r.freq_coef   <= 17'd8704;
      cfg_r.reso_coef   <= 16'd0;
      cfg_r.stage_gain  <= 20'd65536;
      cfg_r.out_gain    <= 20'd65536;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/mmof_mul.sv
// Shared coefficient multiplier with round-half-up Q16 scaling.
`default_nettype none
module mmof_mul (
  input  wire logic        [mmof_pkg::COEF_W-1:0] coef,
  input  wire logic signed [mmof_pkg::OPND_W-1:0] opnd,
  output logic signed      [mmof_pkg::MUL_W-1:0]  prod
);

  localparam int FULL_W = mmof_pkg::COEF_W + 1 + mmof_pkg::OPND_W;

  logic signed [FULL_W-1:0] full;
  logic signed [FULL_W-1:0] rnd;

  always_comb begin
    full = $signed({1'b0, coef}) * opnd;
    rnd  = full + FULL_W'(32768);
  end

  // floor shift by 16 is the upper slice
  assign prod = rnd[16 +: mmof_pkg::MUL_W];

endmodule
`default_nettype wire

>>> design/multimode_onepole_filter.sv
// Top level of the multimode one-pole filter: sequencer, stage state and shared multiplier.
// One sample is processed at a time; in_stall stays high from acceptance until the result
// transaction completes. All work goes through one multiplier: every stage update passes
// the cutoff product, write and decide steps, plus a resonance step with resonance and a
// stage-gain step where the stage gain applies. highN adds a step per stage to advance its
// running highpass, and for its resonant stages after the first one more to scale it by
// the stage gain. A sample makes U stage updates (1 for low1/high1, 2 for band1, N for
// lowN/highN, 2N for bandN), besides the accept step, the output gain step where it
// applies and the result step, which the receiver can stall. Bypass goes from the accept
// step straight to the result step. Stage state resets to zero with rst_n.
`default_nettype none
module multimode_onepole_filter (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_valid,
  output logic                                           in_stall,
  input  wire logic signed [mmof_pkg::SAMPLE_BITS-1:0]   in_sample_in,
  output logic                                           out_valid,
  input  wire logic                                      out_stall,
  output logic signed [mmof_pkg::SAMPLE_BITS-1:0]        out_sample_out,
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [mmof_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  wire logic [mmof_pkg::CFG_DATA_W-1:0]           cfg_data
);

  localparam int SB = mmof_pkg::SAMPLE_BITS;
  localparam int IW = mmof_pkg::IDX_W;
  localparam int SW = mmof_pkg::ST_W;
  localparam int MW = mmof_pkg::MUL_W;
  localparam int OW = mmof_pkg::OPND_W;
  localparam int WW = mmof_pkg::WIDE_W;

  localparam logic signed [MW-1:0] SMAX_W = MW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [MW-1:0] SMIN_W = -SMAX_W - MW'(1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_F    = 4'd1;
  localparam logic [3:0] ST_R    = 4'd2;
  localparam logic [3:0] ST_G    = 4'd3;
  localparam logic [3:0] ST_W    = 4'd4;
  localparam logic [3:0] ST_NX   = 4'd5;
  localparam logic [3:0] ST_T    = 4'd6;
  localparam logic [3:0] ST_TC   = 4'd7;
  localparam logic [3:0] ST_Y    = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  mmof_pkg::cfg_t cfg;

  logic [3:0]             st_r, st_nxt;
  logic signed [SB-1:0]   x_r, x_nxt;
  logic signed [SW-1:0]   tgt_r, tgt_nxt;
  logic signed [SW-1:0]   t_r, t_nxt;
  logic signed [SW-1:0]   last_r, last_nxt;
  logic signed [SW-1:0]   y_r, y_nxt;
  logic signed [MW-1:0]   acc_r, acc_nxt;
  logic signed [MW-1:0]   res_r, res_nxt;
  logic [IW-1:0]          j_r, j_nxt;
  logic [IW-1:0]          nm1_r, nm1_nxt;
  logic                   band_r, band_nxt;
  logic                   rsn_r, rsn_nxt;
  logic                   g_r, g_nxt;

  // the value two samples back is only ever needed as the one-back value before the
  // history shifts, so one history entry per stage is kept
  logic signed [SW-1:0]   low_r  [mmof_pkg::ORDER_MAX];
  logic signed [SW-1:0]   bnd_r  [mmof_pkg::ORDER_MAX];
  logic signed [SW-1:0]   hn_r   [mmof_pkg::ORDER_MAX];

  logic                   rs;
  logic [16:0]            f_eff;
  logic [IW-1:0]          nm1_c;
  logic signed [SW-1:0]   cur;
  logic signed [SW-1:0]   x32;
  logic signed [SW-1:0]   wv;
  logic signed [SW-1:0]   tmp;
  logic [mmof_pkg::COEF_W-1:0] m_coef;
  logic signed [OW-1:0]   m_opnd;
  logic signed [MW-1:0]   prod;

  mmof_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  mmof_mul u_mul (
    .coef (m_coef),
    .opnd (m_opnd),
    .prod (prod)
  );

  assign rs    = (cfg.reso_coef != 16'd0);
  assign f_eff = (cfg.freq_coef > mmof_pkg::FREQ_ONE) ? mmof_pkg::FREQ_ONE : cfg.freq_coef;
  assign cur   = band_r ? bnd_r[j_r] : low_r[j_r];
  assign x32   = SW'(x_r);
  assign wv    = mmof_pkg::sat32(WW'(cur) + WW'(acc_r));

  always_comb begin
    if (cfg.stage_count == 5'd0) begin
      nm1_c = '0;
    end else if (32'(cfg.stage_count) > mmof_pkg::ORDER_MAX) begin
      nm1_c = IW'(mmof_pkg::ORDER_MAX - 1);
    end else begin
      nm1_c = IW'(cfg.stage_count - 5'd1);
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    unique case (st_r)
      ST_R: begin
        m_coef = mmof_pkg::COEF_W'(cfg.reso_coef);
        m_opnd = OW'(cur) - OW'(hn_r[j_r]);
      end
      ST_G: begin
        m_coef = cfg.stage_gain;
        m_opnd = acc_r[OW-1:0];
      end
      ST_T: begin
        m_coef = cfg.stage_gain;
        m_opnd = OW'(t_r);
      end
      ST_Y: begin
        m_coef = cfg.out_gain;
        m_opnd = OW'(y_r);
      end
      default: begin
        m_coef = mmof_pkg::COEF_W'(f_eff);
        m_opnd = OW'(tgt_r) - OW'(cur);
      end
    endcase
  end

  always_comb begin
    st_nxt   = st_r;
    x_nxt    = x_r;
    tgt_nxt  = tgt_r;
    t_nxt    = t_r;
    last_nxt = last_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    j_nxt    = j_r;
    nm1_nxt  = nm1_r;
    band_nxt = band_r;
    rsn_nxt  = rsn_r;
    g_nxt    = g_r;
    tmp      = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          x_nxt    = in_sample_in;
          tgt_nxt  = SW'(in_sample_in);
          j_nxt    = '0;
          band_nxt = 1'b0;
          g_nxt    = 1'b0;
          rsn_nxt  = rs && (cfg.filter_mode != mmof_pkg::MODE_BAND1)
                        && (cfg.filter_mode != mmof_pkg::MODE_BANDN);
          nm1_nxt  = (cfg.filter_mode >= mmof_pkg::MODE_LOWN) ? nm1_c : '0;
          if (cfg.filter_mode == mmof_pkg::MODE_BYPASS ||
              cfg.filter_mode == mmof_pkg::MODE_UNUSED) begin
            res_nxt = MW'(in_sample_in);
            st_nxt  = ST_OUT;
          end else begin
            st_nxt  = ST_F;
          end
        end
      end
      ST_F: begin
        acc_nxt = prod;
        st_nxt  = rsn_r ? ST_R : (g_r ? ST_G : ST_W);
      end
      ST_R: begin
        acc_nxt = acc_r + prod;
        st_nxt  = g_r ? ST_G : ST_W;
      end
      ST_G: begin
        acc_nxt = prod;
        st_nxt  = ST_W;
      end
      ST_W: begin
        last_nxt = wv;
        st_nxt   = ST_NX;
      end
      ST_NX: begin
        unique case (cfg.filter_mode)
          mmof_pkg::MODE_LOW1, mmof_pkg::MODE_HIGH1: begin
            y_nxt = (cfg.filter_mode == mmof_pkg::MODE_LOW1) ? last_r
                                                            : mmof_pkg::sat_sub(x32, last_r);
            if (rs) begin
              st_nxt = ST_Y;
            end else begin
              res_nxt = MW'(y_nxt);
              st_nxt  = ST_OUT;
            end
          end
          mmof_pkg::MODE_LOWN: begin
            if (j_r == nm1_r) begin
              y_nxt = last_r;
              if (rs) begin
                st_nxt = ST_Y;
              end else begin
                res_nxt = MW'(last_r);
                st_nxt  = ST_OUT;
              end
            end else begin
              j_nxt   = IW'(j_r + 1'b1);
              tgt_nxt = last_r;
              g_nxt   = rs;
              st_nxt  = ST_F;
            end
          end
          mmof_pkg::MODE_HIGHN: begin
            tmp   = (j_r == '0) ? mmof_pkg::sat_sub(x32, last_r)
                                : mmof_pkg::sat_sub(t_r, last_r);
            t_nxt = tmp;
            st_nxt = (rs && j_r != '0) ? ST_T : ST_TC;
          end
          mmof_pkg::MODE_BAND1, mmof_pkg::MODE_BANDN: begin
            if (!band_r) begin
              // lowpass of this stage done: feed its complement to the band stage
              tmp      = mmof_pkg::sat_sub(tgt_r, last_r);
              tgt_nxt  = tmp;
              band_nxt = 1'b1;
              rsn_nxt  = rs;
              g_nxt    = rs && (j_r != '0);
              st_nxt   = ST_F;
            end else if (j_r == nm1_r) begin
              y_nxt = last_r;
              if (rs || cfg.filter_mode == mmof_pkg::MODE_BANDN) begin
                st_nxt = ST_Y;
              end else begin
                res_nxt = MW'(last_r);
                st_nxt  = ST_OUT;
              end
            end else begin
              j_nxt    = IW'(j_r + 1'b1);
              tgt_nxt  = last_r;
              band_nxt = 1'b0;
              rsn_nxt  = 1'b0;
              g_nxt    = 1'b0;
              st_nxt   = ST_F;
            end
          end
          default: begin
            res_nxt = MW'(x_r);
            st_nxt  = ST_OUT;
          end
        endcase
      end
      ST_T: begin
        t_nxt  = mmof_pkg::sat32(WW'(prod));
        st_nxt = ST_TC;
      end
      ST_TC: begin
        if (j_r == nm1_r) begin
          y_nxt  = t_r;
          st_nxt = ST_Y;
        end else begin
          j_nxt   = IW'(j_r + 1'b1);
          tgt_nxt = t_r;
          st_nxt  = ST_F;
        end
      end
      ST_Y: begin
        res_nxt = prod;
        st_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    x_r    <= x_nxt;
    tgt_r  <= tgt_nxt;
    t_r    <= t_nxt;
    last_r <= last_nxt;
    y_r    <= y_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
    j_r    <= j_nxt;
    nm1_r  <= nm1_nxt;
    band_r <= band_nxt;
    rsn_r  <= rsn_nxt;
    g_r    <= g_nxt;
  end

  // stage storage: at most one entry written per cycle, at the current stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < mmof_pkg::ORDER_MAX; k++) begin
        low_r[k] <= '0;
        bnd_r[k] <= '0;
        hn_r[k]  <= '0;
      end
    end else begin
      if (st_r == ST_R) begin
        hn_r[j_r] <= cur;
      end
      if (st_r == ST_W) begin
        if (band_r) begin
          bnd_r[j_r] <= wv;
        end else begin
          low_r[j_r] <= wv;
        end
      end
    end
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_OUT);

  always_comb begin
    if (res_r > SMAX_W) begin
      out_sample_out = SMAX_W[SB-1:0];
    end else if (res_r < SMIN_W) begin
      out_sample_out = SMIN_W[SB-1:0];
    end else begin
      out_sample_out = res_r[SB-1:0];
    end
  end

endmodule
`default_nettype wire

>>> design/mmof_chk.sv
// Port-level checker for the multimode one-pole filter, bound to the top level.
`default_nettype none
module mmof_chk (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_valid,
  input wire logic                                 in_stall,
  input wire logic                                 out_valid,
  input wire logic                                 out_stall,
  input wire logic [mmof_pkg::SAMPLE_BITS-1:0]     out_sample_out
);

  // a pending result means the input side is held off
  a_out_holds_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result pending while input open");

  // an accepted sample closes the input until its result is delivered
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("input reopened after accept");

  // one result per sample
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !out_valid) else $error("result repeated");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sample_out)))
    else $error("stalled result changed");

endmodule

bind multimode_onepole_filter mmof_chk u_mmof_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample_out (out_sample_out)
);
`default_nettype wire
